// File: rtl/rss_pkg.sv
package rss_pkg;

    localparam int IMG_ROWS_MAX_DEF = 64;
    localparam int IMG_COLS_MAX_DEF = 64;
    localparam int TPL_ROWS_MAX_DEF = 16;
    localparam int TPL_COLS_MAX_DEF = 16;

    localparam int CMD_W      = 2;
    localparam int COORD_W    = 6;
    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = 3 * CHAN_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int IMG_SIZE_W = 7;
    localparam int TPL_SIZE_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_IMG = 2'd0,
        CMD_WR_TPL = 2'd1,
        CMD_SEARCH = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_ROWS = 2'd0,
        CFG_IMAGE_COLS = 2'd1,
        CFG_TMPL_ROWS  = 2'd2,
        CFG_TMPL_COLS  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CHECK,
        ST_READ,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic wr_img;
        logic wr_tpl;
        logic load_sizes;
        logic clr_scan;
        logic rd_en;
        logic step_tmpl;
        logic step_scan;
        logic out_load;
        logic out_found;
    } t_ctrl;

    typedef struct packed {
        logic fits;
        logic pix_eq;
        logic tmpl_last;
        logic scan_last;
        logic out_busy;
    } t_status;

endpackage

// File: rtl/rss_ctrl.sv
module rss_ctrl
    import rss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_cmd,
    input  t_status          i_status,
    output logic             o_ready,
    output t_ctrl            o_ctrl
);

    t_state r_state, n_state;
    logic   r_found, n_found;
    logic   w_acc;

    assign w_acc = i_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
    end

    always_comb begin
        n_state = r_state;
        n_found = r_found;
        o_ready = 1'b0;
        o_ctrl  = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready       = 1'b1;
                o_ctrl.wr_img = w_acc && (i_cmd == CMD_WR_IMG);
                o_ctrl.wr_tpl = w_acc && (i_cmd == CMD_WR_TPL);
                if (w_acc && (i_cmd == CMD_SEARCH)) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_ctrl.load_sizes = 1'b1;
                o_ctrl.clr_scan   = 1'b1;
                n_state           = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_status.fits) begin
                    n_state = ST_READ;
                end else begin
                    n_found = 1'b0;
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                o_ctrl.rd_en = 1'b1;
                n_state      = ST_CMP;
            end
            ST_CMP: begin
                if (i_status.pix_eq) begin
                    if (i_status.tmpl_last) begin
                        n_found = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        o_ctrl.step_tmpl = 1'b1;
                        n_state          = ST_READ;
                    end
                end else begin
                    if (i_status.scan_last) begin
                        n_found = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        o_ctrl.step_scan = 1'b1;
                        n_state          = ST_READ;
                    end
                end
            end
            ST_DONE: begin
                if (!i_status.out_busy) begin
                    o_ctrl.out_load  = 1'b1;
                    o_ctrl.out_found = r_found;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/rss_datapath.sv
module rss_datapath
    import rss_pkg::*;
#(
    parameter int IMG_ROWS_MAX = IMG_ROWS_MAX_DEF,
    parameter int IMG_COLS_MAX = IMG_COLS_MAX_DEF,
    parameter int TPL_ROWS_MAX = TPL_ROWS_MAX_DEF,
    parameter int TPL_COLS_MAX = TPL_COLS_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl                 i_ctrl,
    output t_status               o_status,
    input  logic [COORD_W-1:0]    i_pix_row,
    input  logic [COORD_W-1:0]    i_pix_col,
    input  logic [PIXEL_W-1:0]    i_pixel,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_out_found,
    output logic [COORD_W-1:0]    o_out_row,
    output logic [COORD_W-1:0]    o_out_col
);

    localparam int IRA    = (IMG_ROWS_MAX > 1) ? $clog2(IMG_ROWS_MAX) : 1;
    localparam int ICA    = (IMG_COLS_MAX > 1) ? $clog2(IMG_COLS_MAX) : 1;
    localparam int TRA    = (TPL_ROWS_MAX > 1) ? $clog2(TPL_ROWS_MAX) : 1;
    localparam int TCA    = (TPL_COLS_MAX > 1) ? $clog2(TPL_COLS_MAX) : 1;
    localparam int IDEPTH = IMG_ROWS_MAX * IMG_COLS_MAX;
    localparam int TDEPTH = TPL_ROWS_MAX * TPL_COLS_MAX;
    localparam int IAW    = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
    localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int IAW1   = IAW + 1;
    localparam int TAW1   = TAW + 1;
    localparam int IRCW   = $clog2(IMG_ROWS_MAX + 1);
    localparam int ICCW   = $clog2(IMG_COLS_MAX + 1);
    localparam int TRCW   = $clog2(TPL_ROWS_MAX + 1);
    localparam int TCCW   = $clog2(TPL_COLS_MAX + 1);

    function automatic int clamp_size(input int v, input int maxv);
        if (v == 0) begin
            return 1;
        end
        if (v > maxv) begin
            return maxv;
        end
        return v;
    endfunction

    logic [PIXEL_W-1:0] r_img_mem [IDEPTH];
    logic [PIXEL_W-1:0] r_tpl_mem [TDEPTH];
    logic [PIXEL_W-1:0] r_img_q;
    logic [PIXEL_W-1:0] r_tpl_q;

    logic [IMG_SIZE_W-1:0] r_cfg_irows;
    logic [IMG_SIZE_W-1:0] r_cfg_icols;
    logic [TPL_SIZE_W-1:0] r_cfg_trows;
    logic [TPL_SIZE_W-1:0] r_cfg_tcols;

    logic [IRCW-1:0] w_ir;
    logic [ICCW-1:0] w_ic;
    logic [TRCW-1:0] w_tr;
    logic [TCCW-1:0] w_tc;

    logic           r_fits;
    logic [IRA-1:0] r_pr_last;
    logic [ICA-1:0] r_pc_last;
    logic [TRA-1:0] r_tr_last;
    logic [TCA-1:0] r_tc_last;

    logic [IRA-1:0] r_scan_r;
    logic [ICA-1:0] r_scan_c;
    logic [TRA-1:0] r_ti;
    logic [TCA-1:0] r_tj;

    logic [IRA-1:0] w_img_r;
    logic [ICA-1:0] w_img_c;
    logic [IAW-1:0] w_img_raddr;
    logic [TAW-1:0] w_tpl_raddr;
    logic [IAW-1:0] w_img_waddr;
    logic [TAW-1:0] w_tpl_waddr;
    logic           w_img_in;
    logic           w_tpl_in;

    logic               r_out_valid;
    logic               r_out_found;
    logic [COORD_W-1:0] r_out_row;
    logic [COORD_W-1:0] r_out_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_irows <= IMG_SIZE_W'(64);
            r_cfg_icols <= IMG_SIZE_W'(64);
            r_cfg_trows <= TPL_SIZE_W'(16);
            r_cfg_tcols <= TPL_SIZE_W'(16);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_ROWS: r_cfg_irows <= i_cfg_data;
                CFG_IMAGE_COLS: r_cfg_icols <= i_cfg_data;
                CFG_TMPL_ROWS:  r_cfg_trows <= i_cfg_data[TPL_SIZE_W-1:0];
                CFG_TMPL_COLS:  r_cfg_tcols <= i_cfg_data[TPL_SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_img_in = (32'(i_pix_row) < IMG_ROWS_MAX) && (32'(i_pix_col) < IMG_COLS_MAX);
    assign w_tpl_in = (32'(i_pix_row) < TPL_ROWS_MAX) && (32'(i_pix_col) < TPL_COLS_MAX);

    assign w_img_waddr = IAW'(IAW1'(IRA'(i_pix_row)) * IAW1'(IMG_COLS_MAX)
                              + IAW1'(ICA'(i_pix_col)));
    assign w_tpl_waddr = TAW'(TAW1'(TRA'(i_pix_row)) * TAW1'(TPL_COLS_MAX)
                              + TAW1'(TCA'(i_pix_col)));

    assign w_img_r     = IRA'(32'(r_scan_r) + 32'(r_ti));
    assign w_img_c     = ICA'(32'(r_scan_c) + 32'(r_tj));
    assign w_img_raddr = IAW'(IAW1'(w_img_r) * IAW1'(IMG_COLS_MAX) + IAW1'(w_img_c));
    assign w_tpl_raddr = TAW'(TAW1'(r_ti) * TAW1'(TPL_COLS_MAX) + TAW1'(r_tj));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_img && w_img_in) begin
            r_img_mem[w_img_waddr] <= i_pixel;
        end
        if (i_ctrl.rd_en) begin
            r_img_q <= r_img_mem[w_img_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_tpl && w_tpl_in) begin
            r_tpl_mem[w_tpl_waddr] <= i_pixel;
        end
        if (i_ctrl.rd_en) begin
            r_tpl_q <= r_tpl_mem[w_tpl_raddr];
        end
    end

    assign w_ir = IRCW'(clamp_size(32'(r_cfg_irows), IMG_ROWS_MAX));
    assign w_ic = ICCW'(clamp_size(32'(r_cfg_icols), IMG_COLS_MAX));
    assign w_tr = TRCW'(clamp_size(32'(r_cfg_trows), TPL_ROWS_MAX));
    assign w_tc = TCCW'(clamp_size(32'(r_cfg_tcols), TPL_COLS_MAX));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_sizes) begin
            r_fits    <= (32'(w_tr) <= 32'(w_ir)) && (32'(w_tc) <= 32'(w_ic));
            r_pr_last <= IRA'(32'(w_ir) - 32'(w_tr));
            r_pc_last <= ICA'(32'(w_ic) - 32'(w_tc));
            r_tr_last <= TRA'(32'(w_tr) - 1);
            r_tc_last <= TCA'(32'(w_tc) - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_r <= '0;
            r_scan_c <= '0;
            r_ti     <= '0;
            r_tj     <= '0;
        end else if (i_ctrl.clr_scan) begin
            r_scan_r <= '0;
            r_scan_c <= '0;
            r_ti     <= '0;
            r_tj     <= '0;
        end else if (i_ctrl.step_scan) begin
            r_ti <= '0;
            r_tj <= '0;
            if (r_scan_c == r_pc_last) begin
                r_scan_c <= '0;
                r_scan_r <= r_scan_r + 1'b1;
            end else begin
                r_scan_c <= r_scan_c + 1'b1;
            end
        end else if (i_ctrl.step_tmpl) begin
            if (r_tj == r_tc_last) begin
                r_tj <= '0;
                r_ti <= r_ti + 1'b1;
            end else begin
                r_tj <= r_tj + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_out_found <= i_ctrl.out_found;
            r_out_row   <= i_ctrl.out_found ? COORD_W'(r_scan_r) : '0;
            r_out_col   <= i_ctrl.out_found ? COORD_W'(r_scan_c) : '0;
        end
    end

    assign o_status.fits      = r_fits;
    assign o_status.pix_eq    = (r_img_q == r_tpl_q);
    assign o_status.tmpl_last = (r_ti == r_tr_last) && (r_tj == r_tc_last);
    assign o_status.scan_last = (r_scan_r == r_pr_last) && (r_scan_c == r_pc_last);
    assign o_status.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_found = r_out_found;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;

endmodule

// File: rtl/rgb_subimage_search_top.sv
// Exact RGB template search. Image and template pixels are loaded one request per cycle while
// no search runs, each at its row and column (red in tdata[19:12], green [27:20], blue
// [35:28]); a search request then tries every placement of the template that lies wholly
// inside the image, row by row, and returns one result: found and the top-left corner of the
// first match, or found low with a zero corner. A search holds tready low through the setup
// and size check, then for every template pixel compared one registered read of the image and
// template memories followed by the compare, with early exit on the first mismatch of a
// placement, and then the load of the result register, held longer while an earlier result
// still waits to be taken. Pixel loads continue while a result waits to be taken. Both stores
// hold undefined data until written.
module rgb_subimage_search_top
    import rss_pkg::*;
#(
    parameter int IMG_ROWS_MAX = IMG_ROWS_MAX_DEF,
    parameter int IMG_COLS_MAX = IMG_COLS_MAX_DEF,
    parameter int TPL_ROWS_MAX = TPL_ROWS_MAX_DEF,
    parameter int TPL_COLS_MAX = TPL_COLS_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [39:0]           i_s_axis_tdata,  // pix_row, pix_col, red, green, blue, zero fill
    input  logic [CMD_W-1:0]      i_s_axis_tuser,  // cmd
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [15:0]           o_m_axis_tdata,  // match_row, match_col, zero fill
    output logic [0:0]            o_m_axis_tuser,  // found
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctrl   w_ctrl;
    t_status w_status;

    logic [COORD_W-1:0] w_pix_row;
    logic [COORD_W-1:0] w_pix_col;
    logic [PIXEL_W-1:0] w_pixel;
    logic               w_out_found;
    logic [COORD_W-1:0] w_out_row;
    logic [COORD_W-1:0] w_out_col;

    assign w_pix_row = i_s_axis_tdata[5:0];
    assign w_pix_col = i_s_axis_tdata[11:6];
    assign w_pixel   = {i_s_axis_tdata[19:12], i_s_axis_tdata[27:20], i_s_axis_tdata[35:28]};

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {4'b0, w_out_col, w_out_row};
    assign o_m_axis_tuser = w_out_found;

    rss_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_cmd    (i_s_axis_tuser),
        .i_status (w_status),
        .o_ready  (o_s_axis_tready),
        .o_ctrl   (w_ctrl)
    );

    rss_datapath #(
        .IMG_ROWS_MAX (IMG_ROWS_MAX),
        .IMG_COLS_MAX (IMG_COLS_MAX),
        .TPL_ROWS_MAX (TPL_ROWS_MAX),
        .TPL_COLS_MAX (TPL_COLS_MAX)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_status    (w_status),
        .i_pix_row   (w_pix_row),
        .i_pix_col   (w_pix_col),
        .i_pixel     (w_pixel),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_found (w_out_found),
        .o_out_row   (w_out_row),
        .o_out_col   (w_out_col)
    );

    a_search_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == CMD_SEARCH))
        |=> !o_s_axis_tready)
        else $error("search request did not hold off the input");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("not-found result carries a nonzero corner");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.out_load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result loaded over a pending result");

endmodule
